>>> design/deq_pkg.sv
package deq_pkg;

  // Default sizes of the queue.
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed widths of the stream fields.
  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Operation codes carried in the input word.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } deq_op_t;

  // Status codes returned in the result word.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } deq_status_t;

  // Shift commands broadcast to every cell; only set when the operation succeeds.
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } deq_ctrl_t;

endpackage

>>> design/deq_cell.sv
module deq_cell #(
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  deq_pkg::deq_ctrl_t    ctrl,
  input  logic [DATA_WIDTH-1:0] push_data,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic                  left_valid,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic                  right_valid,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  valid_o
);

  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic                  valid_r, valid_nxt;

  // A push at the front shifts the row toward the back, a pop at the front
  // shifts it toward the front. The back end only touches the boundary cell.
  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (ctrl.push_front) begin
      data_nxt  = left_data;
      valid_nxt = left_valid;
    end else if (ctrl.pop_front) begin
      data_nxt  = right_data;
      valid_nxt = right_valid;
    end else if (ctrl.push_back) begin
      if (!valid_r && left_valid) begin
        data_nxt  = push_data;
        valid_nxt = 1'b1;
      end
    end else if (ctrl.pop_back) begin
      if (valid_r && !right_valid) begin
        valid_nxt = 1'b0;
      end
    end
  end

  // Only the occupancy bit is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o  = data_r;
  assign valid_o = valid_r;

endmodule

>>> design/double_ended_queue_core.sv
// Latency: a result word appears in the cycle after its input word is accepted.
// Throughput: one word per cycle; the whole row of cells shifts at once
// and the result is held in one output register, so input is taken
// whenever that register is empty or being drained.
// Reset: synchronous active-low rst_n clears the cell occupancy bits, the
// element count and the output valid; stored element data is not cleared.
module double_ended_queue_core #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // op[1:0], value[33:2], zero pad[39:34]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata   // status[1:0], popped_value[33:2], front_value[65:34],
                                   // back_value[97:66], count[102:98], empty_res[103],
                                   // full_res[104], zero pad[111:105]
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  // Input decode.
  deq_pkg::deq_op_t      op_in;
  logic [DATA_WIDTH-1:0] value_w;
  logic                  in_fire;

  assign op_in   = deq_pkg::deq_op_t'(in_tdata[1:0]);
  assign value_w = DATA_WIDTH'(in_tdata[33:2]);
  assign in_fire = in_tvalid && in_tready;

  // Cell row.
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]      cell_valid;
  logic [DEPTH-1:0]      last_vec;
  logic [DEPTH-1:0]      prev_last_vec;
  deq_pkg::deq_ctrl_t    ctrl;

  logic [CNT_W-1:0] count_r, count_nxt;

  logic                    out_valid_r;
  deq_pkg::deq_status_t    status_r, status_nxt;
  logic [DATA_WIDTH-1:0]   popped_r, popped_nxt;
  logic [DATA_WIDTH-1:0]   front_r, front_nxt;
  logic [DATA_WIDTH-1:0]   back_r, back_nxt;
  logic                    empty_r, empty_nxt;
  logic                    full_r, full_nxt;

  logic is_empty, is_full, two_or_more;
  logic [DATA_WIDTH-1:0] back_cur, back_prev, front_cur;

  assign is_empty    = !cell_valid[0];
  assign is_full     = cell_valid[DEPTH-1];
  assign two_or_more = cell_valid[1];

  // The back element sits in the last occupied cell; the one before it is
  // the back after a pop from the back.
  assign last_vec      = cell_valid & ~(cell_valid >> 1);
  assign prev_last_vec = last_vec >> 1;

  always_comb begin
    back_cur  = '0;
    back_prev = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_cur  = back_cur  | (cell_data[i] & {DATA_WIDTH{last_vec[i]}});
      back_prev = back_prev | (cell_data[i] & {DATA_WIDTH{prev_last_vec[i]}});
    end
  end

  assign front_cur = is_empty ? '0 : cell_data[0];

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_d, right_d;
      logic                  left_v, right_v;
      if (g == 0) begin : g_first
        assign left_d = value_w;
        assign left_v = 1'b1;
      end else begin : g_mid_l
        assign left_d = cell_data[g-1];
        assign left_v = cell_valid[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign right_d = '0;
        assign right_v = 1'b0;
      end else begin : g_mid_r
        assign right_d = cell_data[g+1];
        assign right_v = cell_valid[g+1];
      end
      deq_cell #(
        .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .push_data  (value_w),
        .left_data  (left_d),
        .left_valid (left_v),
        .right_data (right_d),
        .right_valid(right_v),
        .data_o     (cell_data[g]),
        .valid_o    (cell_valid[g])
      );
    end
  endgenerate

  // Operation decode, status and the result values after the operation.
  always_comb begin
    ctrl       = '0;
    status_nxt = deq_pkg::ST_OK;
    popped_nxt = '0;
    front_nxt  = front_cur;
    back_nxt   = back_cur;
    count_nxt  = count_r;
    case (op_in)
      deq_pkg::OP_PUSH_FRONT: begin
        if (is_full) begin
          status_nxt = deq_pkg::ST_OVERFLOW;
        end else begin
          ctrl.push_front = in_fire;
          front_nxt       = value_w;
          back_nxt        = is_empty ? value_w : back_cur;
          count_nxt       = count_r + CNT_W'(1);
        end
      end
      deq_pkg::OP_PUSH_BACK: begin
        if (is_full) begin
          status_nxt = deq_pkg::ST_OVERFLOW;
        end else begin
          ctrl.push_back = in_fire;
          front_nxt      = is_empty ? value_w : cell_data[0];
          back_nxt       = value_w;
          count_nxt      = count_r + CNT_W'(1);
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (is_empty) begin
          status_nxt = deq_pkg::ST_UNDERFLOW;
        end else begin
          ctrl.pop_front = in_fire;
          popped_nxt     = cell_data[0];
          front_nxt      = two_or_more ? cell_data[1] : '0;
          back_nxt       = two_or_more ? back_cur : '0;
          count_nxt      = count_r - CNT_W'(1);
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (is_empty) begin
          status_nxt = deq_pkg::ST_UNDERFLOW;
        end else begin
          ctrl.pop_back = in_fire;
          popped_nxt    = back_cur;
          front_nxt     = two_or_more ? cell_data[0] : '0;
          back_nxt      = back_prev;
          count_nxt     = count_r - CNT_W'(1);
        end
      end
      default: begin
        status_nxt = deq_pkg::ST_OK;
      end
    endcase
    empty_nxt = (count_nxt == '0);
    full_nxt  = (count_nxt == CNT_W'(DEPTH));
  end

  // Element count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_fire) begin
      count_r <= count_nxt;
    end
  end

  // Output register: a new word may enter while the current one drains.
  assign in_tready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_nxt;
      popped_r <= popped_nxt;
      front_r  <= front_nxt;
      back_r   <= back_nxt;
      empty_r  <= empty_nxt;
      full_r   <= full_nxt;
    end
  end

  logic [CNT_W-1:0] count_out_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      count_out_r <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, full_r, empty_r, deq_pkg::COUNT_W'(count_out_r),
                       32'(back_r), 32'(front_r), 32'(popped_r), status_r};

  // The occupied cells always form one unbroken run from the front.
  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("occupied cells are not contiguous from the front");

  // The element count tracks the number of occupied cells.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(count_r))
    else $error("element count disagrees with occupied cells");

  // A pop from an empty queue reports underflow and leaves the cells alone.
  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_empty &&
     (op_in == deq_pkg::OP_POP_FRONT || op_in == deq_pkg::OP_POP_BACK))
    |=> (status_r == deq_pkg::ST_UNDERFLOW) && (cell_valid == '0))
    else $error("pop from empty queue not flagged as underflow");

endmodule

>>> dv/tb_double_ended_queue_core.sv
module tb_double_ended_queue_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = deq_pkg::DEPTH_DEF;

  // One result word as laid out in out_tdata, the status in the lowest bits.
  typedef struct packed {
    logic                        full_res;
    logic                        empty_res;
    logic [deq_pkg::COUNT_W-1:0] count;
    logic [31:0]                 back_value;
    logic [31:0]                 front_value;
    logic [31:0]                 popped_value;
    deq_pkg::deq_status_t        status;
  } deq_result_t;

  // One entry of the send list; a pause entry holds the sender until all results are in.
  typedef struct {
    bit               pause;
    deq_pkg::deq_op_t op;
    logic [31:0]      value;
  } deq_request_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [39:0]  in_tdata   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;

  double_ended_queue_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  deq_request_t requests_to_send[$];
  deq_result_t  results_due[$];
  int           mismatches = 0;

  // Shadow copy of the deque contents.
  logic [31:0]                 shadow_slots [DEPTH];
  logic [3:0]                  shadow_head  = '0;
  logic [deq_pkg::COUNT_W-1:0] shadow_count = '0;

  // Sender and receiver bookkeeping.
  logic in_word_taken = 1'b0;
  logic long_hold     = 1'b0;
  bit   pause_active  = 1'b0;
  int   burst_left    = 8;
  int   gap_left      = 0;
  int   rx_cycles     = 0;
  int   rx_mode       = 0;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Apply one operation to the shadow deque and return the result word it should produce.
  function automatic deq_result_t shadow_deque_apply(deq_pkg::deq_op_t op, logic [31:0] val);
    deq_result_t r;
    logic [3:0]  idx;
    r = '0;
    r.status = deq_pkg::ST_OK;
    if (op == deq_pkg::OP_PUSH_FRONT || op == deq_pkg::OP_PUSH_BACK) begin
      if (shadow_count == DEPTH) begin
        r.status = deq_pkg::ST_OVERFLOW;
      end else if (op == deq_pkg::OP_PUSH_FRONT) begin
        shadow_head = shadow_head - 4'd1;
        shadow_slots[shadow_head] = val;
        shadow_count = shadow_count + 5'd1;
      end else begin
        idx = 4'(shadow_head + shadow_count);
        shadow_slots[idx] = val;
        shadow_count = shadow_count + 5'd1;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = deq_pkg::ST_UNDERFLOW;
      end else if (op == deq_pkg::OP_POP_FRONT) begin
        r.popped_value = shadow_slots[shadow_head];
        shadow_head = shadow_head + 4'd1;
        shadow_count = shadow_count - 5'd1;
      end else begin
        idx = 4'(shadow_head + shadow_count - 5'd1);
        r.popped_value = shadow_slots[idx];
        shadow_count = shadow_count - 5'd1;
      end
    end
    // Front and back read zero when nothing is stored.
    if (shadow_count != 0) begin
      idx = 4'(shadow_head + shadow_count - 5'd1);
      r.front_value = shadow_slots[shadow_head];
      r.back_value  = shadow_slots[idx];
    end
    r.count     = shadow_count;
    r.empty_res = (shadow_count == 0);
    r.full_res  = (shadow_count == DEPTH);
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
    end
  endtask

  task automatic queue_op(deq_pkg::deq_op_t op, logic [31:0] val);
    deq_request_t r;
    r.pause = 1'b0;
    r.op    = op;
    r.value = val;
    requests_to_send.push_back(r);
  endtask

  task automatic queue_pause();
    deq_request_t r;
    r.pause = 1'b1;
    r.op    = deq_pkg::OP_PUSH_FRONT;
    r.value = '0;
    requests_to_send.push_back(r);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Check each returned word and predict each accepted request at the rising edge.
  always @(posedge clk) begin
    deq_result_t want;
    deq_result_t got;
    in_word_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = deq_result_t'(out_tdata[104:0]);
        if (results_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word, expected none, actual %h", $realtime,
                   out_tdata);
        end else begin
          want = results_due.pop_front();
          compare_field("status", 32'(want.status), 32'(got.status));
          compare_field("popped_value", want.popped_value, got.popped_value);
          compare_field("front_value", want.front_value, got.front_value);
          compare_field("back_value", want.back_value, got.back_value);
          compare_field("count", 32'(want.count), 32'(got.count));
          compare_field("empty_res", 32'(want.empty_res), 32'(got.empty_res));
          compare_field("full_res", 32'(want.full_res), 32'(got.full_res));
          compare_field("pad", 32'd0, 32'(out_tdata[111:105]));
        end
      end
      if (in_tvalid && in_tready)
        results_due.push_back(shadow_deque_apply(deq_pkg::deq_op_t'(in_tdata[1:0]),
                                                 in_tdata[33:2]));
    end
  end

  // Sender: works through the request list in bursts, holding each word until it is taken.
  always @(negedge clk) begin
    logic        nxt_valid;
    logic [39:0] nxt_data;
    deq_request_t r;
    nxt_valid = in_tvalid;
    nxt_data  = in_tdata;
    if (!rst_n) begin
      nxt_valid = 1'b0;
      nxt_data  = '0;
    end else if (!(in_tvalid && !in_word_taken)) begin
      nxt_valid = 1'b0;
      if (in_word_taken) begin
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (pause_active) begin
        if (results_due.size() == 0)
          pause_active = 1'b0;
      end else if (gap_left > 0 && !long_hold) begin
        gap_left--;
      end else if (requests_to_send.size() > 0) begin
        r = requests_to_send.pop_front();
        if (r.pause) begin
          pause_active = 1'b1;
        end else begin
          nxt_valid = 1'b1;
          nxt_data  = {6'b0, r.value, r.op};
        end
      end
    end
    in_tvalid <= nxt_valid;
    in_tdata  <= nxt_data;
  end

  // Receiver: cycles through stall patterns, with two long hold-offs at fixed points.
  always @(negedge clk) begin
    logic hold;
    logic rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cycles++;
      if (rx_cycles % 150 == 0)
        rx_mode = $urandom_range(0, 3);
      hold = (rx_cycles >= 400 && rx_cycles < 520) || (rx_cycles >= 3000 && rx_cycles < 3090);
      case (rx_mode)
        0:       rdy = 1'b1;
        1:       rdy = ($urandom_range(0, 1) == 1);
        2:       rdy = ($urandom_range(0, 3) == 0);
        default: rdy = (rx_cycles % 5 != 0);
      endcase
      long_hold  <= hold;
      out_tready <= rdy && !hold;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int seg_len;
    int push_pct;
    int total;
    deq_pkg::deq_op_t op;
    rst_n = 1'b0;

    // Directed part: pops on empty, extreme values, fill to full, then overflow of both kinds.
    queue_op(deq_pkg::OP_POP_FRONT, 32'hFFFF_FFFF);
    queue_op(deq_pkg::OP_POP_BACK, 32'h0000_0000);
    queue_op(deq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF);
    queue_op(deq_pkg::OP_PUSH_BACK, 32'h0000_0000);
    queue_op(deq_pkg::OP_POP_FRONT, 32'h1234_5678);
    queue_op(deq_pkg::OP_POP_BACK, 32'h8765_4321);
    for (int i = 0; i < DEPTH; i++)
      queue_op(i[0] ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK,
               i[1] ? 32'hAAAA_AAAA : 32'h5555_5555);
    queue_op(deq_pkg::OP_PUSH_FRONT, 32'hDEAD_BEEF);
    queue_op(deq_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF);
    queue_pause();

    // Random part: segments that lean toward pushing, popping or neither.
    total = 0;
    while (total < 1750) begin
      seg_len = $urandom_range(8, 60);
      case ($urandom_range(0, 2))
        0:       push_pct = 15;
        1:       push_pct = 50;
        default: push_pct = 85;
      endcase
      for (int i = 0; i < seg_len; i++) begin
        if ($urandom_range(0, 99) < push_pct)
          op = $urandom_range(0, 1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
        else
          op = $urandom_range(0, 1) ? deq_pkg::OP_POP_BACK : deq_pkg::OP_POP_FRONT;
        queue_op(op, pick_value());
      end
      total += seg_len;
      if ($urandom_range(0, 19) == 0)
        queue_pause();
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Wait until every request is sent and every result has come back.
    while (requests_to_send.size() != 0 || in_tvalid || pause_active || results_due.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> sim.f
design/deq_pkg.sv
design/deq_cell.sv
design/double_ended_queue_core.sv
dv/tb_double_ended_queue_core.sv
